FILE: rtl/tgch_pkg.sv
// Shared types, constants and helper functions for the ternary gradient cell histogram.
// Used by every module of the block but tgch_ram; it depends on nothing else.
`default_nettype none

package tgch_pkg;

    localparam int DATA_W       = 16;
    localparam int FRAC_BITS    = 8;
    localparam int NUM_BINS     = 9;
    localparam int BIN_W        = 4;
    localparam int ACC_W        = 15;
    localparam int IDX_W        = 2;
    localparam int ADDR_W       = IDX_W + 1;
    localparam int RAM_DEPTH    = 1 << ADDR_W;
    localparam int THRESH_RESET = 30;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // sqrt(2) in Q30, rounded to the nearest step.
    localparam longint unsigned SQRT2_Q30 = 64'd1518500250;
    localparam longint unsigned RND_Q30   = 64'd1 << (31 - FRAC_BITS);

    localparam logic [ACC_W-1:0] W_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic [ACC_W-1:0] W_ONE  = ACC_W'(1 << FRAC_BITS);
    localparam logic [ACC_W-1:0] W_Q    =
        ACC_W'((SQRT2_Q30 + RND_Q30) >> (32 - FRAC_BITS));
    localparam logic [ACC_W-1:0] W_TQ   =
        ACC_W'((64'd3 * SQRT2_Q30 + RND_Q30) >> (32 - FRAC_BITS));

    // Orientation classes; each is also the entry index in both accumulator memories.
    typedef logic [IDX_W-1:0] t_code;
    localparam t_code ORI_0   = 2'd0;
    localparam t_code ORI_45  = 2'd1;
    localparam t_code ORI_90  = 2'd2;
    localparam t_code ORI_135 = 2'd3;

    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [DATA_W-1:0] left_depth;
        logic [DATA_W-1:0] right_depth;
        logic [DATA_W-1:0] above_depth;
        logic [DATA_W-1:0] below_depth;
        logic              last_of_cell;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0] bin_number;
        logic [ACC_W-1:0] bin_weight;
        logic             last_bin;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic bank;
    } t_emit_req;

    typedef struct packed {
        t_acc                 rd_a;
        t_acc                 rd_b;
        logic [RAM_DEPTH-1:0] vld_a;
        logic [RAM_DEPTH-1:0] vld_b;
    } t_emit_rd;

    typedef struct packed {
        logic  from_a;
        logic  from_b;
        t_code idx;
    } t_bin_src;

    // Memory A holds bins 0, 1, 4 and 6; memory B holds bins 8, 2 and 7.
    function automatic t_acc weight_a(input t_code code);
        t_acc w;
        case (code)
            ORI_0:   w = W_HALF;
            ORI_45:  w = W_Q;
            ORI_90:  w = W_ONE;
            ORI_135: w = W_TQ;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic t_acc weight_b(input t_code code);
        t_acc w;
        case (code)
            ORI_0:   w = W_HALF;
            ORI_45:  w = W_TQ;
            ORI_135: w = W_Q;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Where each bin lives. Bins 3 and 5 never receive weight and read as zero.
    function automatic t_bin_src bin_src(input logic [BIN_W-1:0] bin);
        t_bin_src s;
        s = '{from_a: 1'b0, from_b: 1'b0, idx: ORI_0};
        case (bin)
            4'd0: s = '{from_a: 1'b1, from_b: 1'b0, idx: ORI_0};
            4'd1: s = '{from_a: 1'b1, from_b: 1'b0, idx: ORI_45};
            4'd2: s = '{from_a: 1'b0, from_b: 1'b1, idx: ORI_45};
            4'd4: s = '{from_a: 1'b1, from_b: 1'b0, idx: ORI_90};
            4'd6: s = '{from_a: 1'b1, from_b: 1'b0, idx: ORI_135};
            4'd7: s = '{from_a: 1'b0, from_b: 1'b1, idx: ORI_135};
            4'd8: s = '{from_a: 1'b0, from_b: 1'b1, idx: ORI_0};
            default: s = '{from_a: 1'b0, from_b: 1'b0, idx: ORI_0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tgch_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// Stands alone; no package is needed.
`default_nettype none

module tgch_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/tgch_accum.sv
// Gradient quantiser and read-modify-write pipeline over the two accumulator memories.
// Depends on tgch_pkg and tgch_ram.
`default_nettype none

module tgch_accum (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire tgch_pkg::t_in_item         i_item,
    input  wire logic [tgch_pkg::DATA_W-1:0] i_thresh,
    input  wire tgch_pkg::t_addr            i_emit_addr,
    output tgch_pkg::t_emit_req             o_emit,
    output tgch_pkg::t_emit_rd              o_emit_rd
);

    // Quantiser, combinational on the accepted item.
    logic signed [tgch_pkg::DATA_W+1:0] w_dx, w_dy, w_t, w_dx_t, w_dy_t;
    logic                               w_x_nz, w_x_pos, w_y_nz, w_y_pos;
    logic                               w_upd;
    tgch_pkg::t_code                    w_code;

    always_comb begin
        w_dx    = $signed({2'b00, i_item.right_depth}) - $signed({2'b00, i_item.left_depth});
        w_dy    = $signed({2'b00, i_item.below_depth}) - $signed({2'b00, i_item.above_depth});
        w_t     = $signed({2'b00, i_thresh});
        w_dx_t  = w_dx + w_t;
        w_dy_t  = w_dy + w_t;
        // A difference at or above the threshold is a rising step, at or below
        // minus the threshold a falling one, and anything between is flat.
        w_x_pos = (w_dx >= w_t);
        w_y_pos = (w_dy >= w_t);
        w_x_nz  = w_x_pos || (w_dx_t <= 0);
        w_y_nz  = w_y_pos || (w_dy_t <= 0);
        w_upd   = w_x_nz || w_y_nz;
        if (w_x_nz && !w_y_nz) begin
            w_code = tgch_pkg::ORI_0;
        end else if (!w_x_nz) begin
            w_code = tgch_pkg::ORI_90;
        end else if (w_x_pos == w_y_pos) begin
            w_code = tgch_pkg::ORI_45;
        end else begin
            w_code = tgch_pkg::ORI_135;
        end
    end

    // Bank per cell, valid bits per entry.
    logic                              r_bank;
    logic [tgch_pkg::RAM_DEPTH-1:0]    r_vld_a, r_vld_b, n_vld_a, n_vld_b;

    // Second stage: memory data returns here and the sum is written back.
    logic               r_s1_valid, r_s1_upd, r_s1_last, r_s1_bank;
    tgch_pkg::t_code    r_s1_code;
    tgch_pkg::t_addr    w_rd_addr, w_s1_addr;

    // Last write to each memory, forwarded to the item directly behind it.
    logic               r_fwd_a_vld, r_fwd_b_vld;
    tgch_pkg::t_addr    r_fwd_addr;
    tgch_pkg::t_acc     r_fwd_a, r_fwd_b;

    tgch_pkg::t_acc     w_rd_a, w_rd_b, w_old_a, w_old_b, w_new_a, w_new_b;
    logic [tgch_pkg::ACC_W:0] w_sum_a, w_sum_b;
    logic               w_we_a, w_we_b;

    assign w_rd_addr = {r_bank, w_code};
    assign w_s1_addr = {r_s1_bank, r_s1_code};

    tgch_ram #(
        .WIDTH (tgch_pkg::ACC_W),
        .DEPTH (tgch_pkg::RAM_DEPTH)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (w_we_a),
        .i_waddr   (w_s1_addr),
        .i_wdata   (w_new_a),
        .i_raddr_a (w_rd_addr),
        .i_raddr_b (i_emit_addr),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (o_emit_rd.rd_a)
    );

    tgch_ram #(
        .WIDTH (tgch_pkg::ACC_W),
        .DEPTH (tgch_pkg::RAM_DEPTH)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (w_we_b),
        .i_waddr   (w_s1_addr),
        .i_wdata   (w_new_b),
        .i_raddr_a (w_rd_addr),
        .i_raddr_b (i_emit_addr),
        .o_rdata_a (w_rd_b),
        .o_rdata_b (o_emit_rd.rd_b)
    );

    always_comb begin
        if (r_fwd_a_vld && (r_fwd_addr == w_s1_addr)) begin
            w_old_a = r_fwd_a;
        end else if (r_vld_a[w_s1_addr]) begin
            w_old_a = w_rd_a;
        end else begin
            w_old_a = '0;
        end
        if (r_fwd_b_vld && (r_fwd_addr == w_s1_addr)) begin
            w_old_b = r_fwd_b;
        end else if (r_vld_b[w_s1_addr]) begin
            w_old_b = w_rd_b;
        end else begin
            w_old_b = '0;
        end
        w_sum_a = {1'b0, w_old_a} + {1'b0, tgch_pkg::weight_a(r_s1_code)};
        w_sum_b = {1'b0, w_old_b} + {1'b0, tgch_pkg::weight_b(r_s1_code)};
        w_new_a = w_sum_a[tgch_pkg::ACC_W] ? tgch_pkg::ACC_MAX : w_sum_a[tgch_pkg::ACC_W-1:0];
        w_new_b = w_sum_b[tgch_pkg::ACC_W] ? tgch_pkg::ACC_MAX : w_sum_b[tgch_pkg::ACC_W-1:0];
        w_we_a  = r_s1_valid && r_s1_upd;
        w_we_b  = r_s1_valid && r_s1_upd && (r_s1_code != tgch_pkg::ORI_90);
    end

    always_comb begin
        n_vld_a = r_vld_a;
        n_vld_b = r_vld_b;
        // The bank that the next cell will use starts out empty.
        if (i_accept && i_item.last_of_cell) begin
            for (int i = 0; i < (1 << tgch_pkg::IDX_W); i++) begin
                n_vld_a[{~r_bank, tgch_pkg::IDX_W'(i)}] = 1'b0;
                n_vld_b[{~r_bank, tgch_pkg::IDX_W'(i)}] = 1'b0;
            end
        end
        if (w_we_a) begin
            n_vld_a[w_s1_addr] = 1'b1;
        end
        if (w_we_b) begin
            n_vld_b[w_s1_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_vld_a     <= '0;
            r_vld_b     <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_a_vld <= 1'b0;
            r_fwd_b_vld <= 1'b0;
        end else begin
            r_vld_a     <= n_vld_a;
            r_vld_b     <= n_vld_b;
            r_s1_valid  <= i_accept;
            r_fwd_a_vld <= w_we_a;
            r_fwd_b_vld <= w_we_b;
            if (i_accept && i_item.last_of_cell) begin
                r_bank <= ~r_bank;
            end
        end
        r_s1_upd   <= w_upd;
        r_s1_code  <= w_code;
        r_s1_bank  <= r_bank;
        r_s1_last  <= i_item.last_of_cell;
        r_fwd_addr <= w_s1_addr;
        r_fwd_a    <= w_new_a;
        r_fwd_b    <= w_new_b;
    end

    assign o_emit.start    = r_s1_valid && r_s1_last;
    assign o_emit.bank     = r_s1_bank;
    assign o_emit_rd.vld_a = r_vld_a;
    assign o_emit_rd.vld_b = r_vld_b;

endmodule

`default_nettype wire

FILE: rtl/tgch_emit.sv
// Result sequencer: reads the nine bins of a finished cell and drives the output register.
// Depends on tgch_pkg; reads the accumulator memories through tgch_accum.
`default_nettype none

module tgch_emit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tgch_pkg::t_emit_req i_emit,
    input  wire tgch_pkg::t_emit_rd  i_emit_rd,
    output tgch_pkg::t_addr          o_emit_addr,
    output logic                     o_busy,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tgch_pkg::t_out_item      o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state                       r_state;
    logic [tgch_pkg::BIN_W-1:0]   r_bin;
    logic                         r_bank;
    tgch_pkg::t_bin_src           w_src;
    tgch_pkg::t_acc               w_weight;
    logic                         w_last;

    always_comb begin
        w_src       = tgch_pkg::bin_src(r_bin);
        o_emit_addr = {r_bank, w_src.idx};
        if (w_src.from_a && i_emit_rd.vld_a[o_emit_addr]) begin
            w_weight = i_emit_rd.rd_a;
        end else if (w_src.from_b && i_emit_rd.vld_b[o_emit_addr]) begin
            w_weight = i_emit_rd.rd_b;
        end else begin
            w_weight = '0;
        end
        w_last = (r_bin == tgch_pkg::BIN_W'(tgch_pkg::NUM_BINS - 1));
        o_busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // While sending, the output register is either reloaded or left waiting.
            if (o_out_valid && i_out_ready && (r_state != S_SEND)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_emit.start) begin
                        r_bank  <= i_emit.bank;
                        r_bin   <= '0;
                        r_state <= S_READ;
                    end
                end
                // The memory address for r_bin is presented; data is there next cycle.
                S_READ: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid      <= 1'b1;
                        o_out.bin_number <= r_bin;
                        o_out.bin_weight <= w_weight;
                        o_out.last_bin   <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_bin   <= r_bin + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ternary_gradient_cell_histogram_core.sv
// Top level of the ternary gradient cell histogram: threshold register, accumulator
// pipeline and result sequencer. Depends on tgch_pkg, tgch_accum and tgch_emit.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready     | i_in  (tgch_pkg::t_in_item)
//   out     | output    | o_out_valid / i_out_ready   | o_out (tgch_pkg::t_out_item)
//   cfg     | input     | i_cfg_we, no wait           | i_cfg_wdata (threshold)
//
// One pixel item is accepted per cycle while o_in_ready is high; its bins are read,
// updated and written back, with the previous write forwarded when both touch the same
// entry. A cell's last item starts nine results, each read and then sent before the
// next bin is read; a last item is held off while the previous cell still emits.
// Reset is synchronous and needs no clearing pass: per-entry valid bits empty both banks.
`default_nettype none

module ternary_gradient_cell_histogram_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire tgch_pkg::t_in_item          i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output tgch_pkg::t_out_item              o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [tgch_pkg::DATA_W-1:0] i_cfg_wdata
);

    logic [tgch_pkg::DATA_W-1:0] r_thresh;
    logic                        w_accept;
    logic                        w_emit_busy;
    tgch_pkg::t_emit_req         w_emit;
    tgch_pkg::t_emit_rd          w_emit_rd;
    tgch_pkg::t_addr             w_emit_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tgch_pkg::DATA_W'(tgch_pkg::THRESH_RESET);
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // A finished cell is still being read out while its start request or sequencer runs.
    assign o_in_ready = !(i_in.last_of_cell && (w_emit.start || w_emit_busy));
    assign w_accept   = i_in_valid && o_in_ready;

    tgch_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in),
        .i_thresh    (r_thresh),
        .i_emit_addr (w_emit_addr),
        .o_emit      (w_emit),
        .o_emit_rd   (w_emit_rd)
    );

    tgch_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (w_emit),
        .i_emit_rd   (w_emit_rd),
        .o_emit_addr (w_emit_addr),
        .o_busy      (w_emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: dv/tb_ternary_gradient_cell_histogram_core.sv
// Self-checking testbench for ternary_gradient_cell_histogram_core: pixel items go in,
// and the nine bin results of each cell are checked against an in-bench histogram model.
// Depends on tgch_pkg and the core RTL only.
module tb_ternary_gradient_cell_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DEPTH_MAX    = 65535;
    localparam int ACC_LIMIT    = 32767;

    // Weights in Q.8: one half, one, sqrt2/4 and 3*sqrt2/4, rounded to nearest.
    localparam int WGT_HALF = 128;
    localparam int WGT_ONE  = 256;
    localparam int WGT_Q    = 91;
    localparam int WGT_TQ   = 272;

    // Bins by centre angle.
    localparam int BIN_10  = 0;
    localparam int BIN_30  = 1;
    localparam int BIN_50  = 2;
    localparam int BIN_90  = 4;
    localparam int BIN_130 = 6;
    localparam int BIN_150 = 7;
    localparam int BIN_170 = 8;

    typedef enum int {TRI_NEG = -1, TRI_ZERO = 0, TRI_POS = 1} tri_e;
    typedef enum int {GRAD_ANY, GRAD_NONE, GRAD_0, GRAD_45, GRAD_90, GRAD_135} grad_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    tgch_pkg::t_in_item pix_item = '0;
    logic bin_valid;
    logic bin_ready = 1'b0;
    tgch_pkg::t_out_item bin_item;
    logic cfg_we = 1'b0;
    logic [tgch_pkg::DATA_W-1:0] cfg_wdata = '0;

    tgch_pkg::t_in_item  pixel_queue[$];
    tgch_pkg::t_out_item expected_bins[$];
    tgch_pkg::t_out_item want;
    logic [tgch_pkg::ACC_W-1:0] bin_acc [tgch_pkg::NUM_BINS];

    int thr_model = 30;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int pixels_taken = 0;
    int cells_done = 0;
    int results_checked = 0;
    int sat_adds = 0;

    ternary_gradient_cell_histogram_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .o_in_ready  (pix_ready),
        .i_in        (pix_item),
        .o_out_valid (bin_valid),
        .i_out_ready (bin_ready),
        .o_out       (bin_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic tri_e ternary_of(input int d, input int thr);
        if (d >= thr) return TRI_POS;
        if ((d < 0 ? -d : d) < thr) return TRI_ZERO;
        return TRI_NEG;
    endfunction

    function automatic void add_weight(input int bin, input int w);
        int sum;
        sum = int'(bin_acc[bin]) + w;
        if (sum > ACC_LIMIT) begin
            sum = ACC_LIMIT;
            sat_adds++;
        end
        bin_acc[bin] = 15'(sum);
    endfunction

    // Histogram model: spreads one pixel's gradient over the bins and, on the last
    // pixel of a cell, queues the nine bin results and clears the histogram.
    function automatic void accumulate_pixel(input tgch_pkg::t_in_item px);
        int l, r, a, b;
        tri_e qx, qy;
        tgch_pkg::t_out_item res;
        l = px.left_depth;
        r = px.right_depth;
        a = px.above_depth;
        b = px.below_depth;
        qx = ternary_of(r - l, thr_model);
        qy = ternary_of(b - a, thr_model);
        if (qx != TRI_ZERO && qy == TRI_ZERO) begin
            add_weight(BIN_170, WGT_HALF);
            add_weight(BIN_10, WGT_HALF);
        end else if (qx == TRI_ZERO && qy != TRI_ZERO) begin
            add_weight(BIN_90, WGT_ONE);
        end else if (qx != TRI_ZERO && qx == qy) begin
            add_weight(BIN_30, WGT_Q);
            add_weight(BIN_50, WGT_TQ);
        end else if (qx != TRI_ZERO) begin
            add_weight(BIN_130, WGT_TQ);
            add_weight(BIN_150, WGT_Q);
        end
        if (px.last_of_cell) begin
            for (int k = 0; k < tgch_pkg::NUM_BINS; k++) begin
                res.bin_number = 4'(k);
                res.bin_weight = bin_acc[k];
                res.last_bin   = (k == tgch_pkg::NUM_BINS - 1);
                expected_bins = {expected_bins, res};
                bin_acc[k] = '0;
            end
            cells_done++;
        end
    endfunction

    initial begin
        for (int k = 0; k < tgch_pkg::NUM_BINS; k++) begin
            bin_acc[k] = '0;
        end
    end

    // Pixel driver: valid is held with the item until it is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && pix_ready) begin
                accumulate_pixel(pix_item);
                pixels_taken++;
            end
            if (!pix_valid || pix_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_item  <= pixel_queue.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Bin result monitor, which also owns the receiver's ready and its long hold-off.
    always @(posedge clk) begin
        if (rst_n && bin_valid && bin_ready) begin
            if (expected_bins.size() == 0) begin
                $display("%0t: unexpected bin result, expected none, got %0s",
                         $time, $sformatf("bin=%0d weight=%0d last=%0d",
                         bin_item.bin_number, bin_item.bin_weight, bin_item.last_bin));
                errors++;
            end else begin
                want = expected_bins.pop_front();
                if (bin_item.bin_number !== want.bin_number ||
                    bin_item.bin_weight !== want.bin_weight ||
                    bin_item.last_bin !== want.last_bin) begin
                    $display("%0t: bin result mismatch, expected %0s, got %0s", $time,
                             $sformatf("bin=%0d weight=%0d last=%0d", want.bin_number,
                                       want.bin_weight, want.last_bin),
                             $sformatf("bin=%0d weight=%0d last=%0d", bin_item.bin_number,
                                       bin_item.bin_weight, bin_item.last_bin));
                    errors++;
                end
                results_checked++;
            end
        end
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            bin_ready <= 1'b0;
        end else begin
            bin_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((pix_valid && pix_ready) || (bin_valid && bin_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic settle();
        while (pixel_queue.size() != 0 || pix_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input int value);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 16'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_model = value;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic push_px(input int l, input int r, input int a, input int b,
                           input bit last);
        tgch_pkg::t_in_item px;
        px.left_depth   = 16'(l);
        px.right_depth  = 16'(r);
        px.above_depth  = 16'(a);
        px.below_depth  = 16'(b);
        px.last_of_cell = last;
        pixel_queue = {pixel_queue, px};
    endtask

    // Picks two depths whose difference (to - from) quantizes to q, often on the edge.
    task automatic make_pair(input tri_e q, input int thr,
                             output logic [15:0] from_px, output logic [15:0] to_px);
        int d, m, base;
        bit edge_hit;
        edge_hit = ($urandom_range(3) == 0);
        case (q)
            TRI_POS: begin
                d = edge_hit ? thr : int'($urandom_range(DEPTH_MAX, thr));
            end
            TRI_ZERO: begin
                m = (thr == 0) ? 0 : thr - 1;
                if (m > DEPTH_MAX) m = DEPTH_MAX;
                d = edge_hit ? ($urandom_range(1) ? m : -m)
                             : int'($urandom_range(2 * m, 0)) - m;
            end
            default: begin
                m = (thr == 0) ? 1 : thr;
                d = edge_hit ? -m : -int'($urandom_range(DEPTH_MAX, m));
            end
        endcase
        if (d >= 0) base = $urandom_range(DEPTH_MAX - d, 0);
        else        base = $urandom_range(DEPTH_MAX, -d);
        from_px = 16'(base);
        to_px   = 16'(base + d);
    endtask

    // Queues one cell; unforced items are mostly of a chosen gradient class, some noise.
    task automatic queue_cell(input int len, input grad_e forced);
        grad_e cls;
        tri_e tx, ty, s;
        logic [15:0] l, r, a, b;
        tgch_pkg::t_in_item px;
        for (int i = 0; i < len; i++) begin
            cls = forced;
            if (cls == GRAD_ANY && $urandom_range(9) >= 3)
                cls = grad_e'($urandom_range(GRAD_135, GRAD_NONE));
            if (cls == GRAD_ANY) begin
                px.left_depth  = 16'($urandom);
                px.right_depth = 16'($urandom);
                px.above_depth = 16'($urandom);
                px.below_depth = 16'($urandom);
            end else begin
                s = $urandom_range(1) ? TRI_POS : TRI_NEG;
                tx = TRI_ZERO;
                ty = TRI_ZERO;
                case (cls)
                    GRAD_0:   tx = s;
                    GRAD_90:  ty = s;
                    GRAD_45: begin
                        tx = s;
                        ty = s;
                    end
                    GRAD_135: begin
                        tx = s;
                        ty = (s == TRI_POS) ? TRI_NEG : TRI_POS;
                    end
                    default: ;
                endcase
                make_pair(tx, thr_model, l, r);
                make_pair(ty, thr_model, a, b);
                px.left_depth  = l;
                px.right_depth = r;
                px.above_depth = a;
                px.below_depth = b;
            end
            px.last_of_cell = (i == len - 1);
            pixel_queue = {pixel_queue, px};
        end
    endtask

    task automatic queue_random_cells(input int min_items, input int max_len);
        int n, len;
        n = 0;
        while (n < min_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(16, 1)
                                           : $urandom_range(max_len, 1);
            queue_cell(len, GRAD_ANY);
            n += len;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(10, 57);

        // Reset threshold: zero gradient, steps exactly at the threshold, one short of
        // it, full-scale depths, every orientation, a lone last pixel and an empty cell.
        push_px(1000, 1000, 1000, 1000, 1'b0);
        push_px(100, 130, 500, 500, 1'b0);
        push_px(130, 100, 500, 529, 1'b0);
        push_px(0, 0, 65535, 0, 1'b0);
        push_px(0, 65535, 0, 65535, 1'b0);
        push_px(65535, 0, 65535, 0, 1'b0);
        push_px(0, 65535, 65535, 0, 1'b0);
        push_px(65535, 0, 0, 65535, 1'b1);
        push_px(40, 11, 7, 36, 1'b1);
        push_px(65535, 65535, 65535, 65535, 1'b1);

        // A zero threshold turns a flat difference into a positive step.
        set_threshold(0);
        push_px(5, 5, 5, 5, 1'b0);
        push_px(6, 5, 5, 5, 1'b1);

        set_threshold(65535);
        push_px(0, 65535, 300, 300, 1'b0);
        push_px(65535, 0, 0, 65534, 1'b0);
        push_px(1, 65535, 0, 65535, 1'b1);

        set_threshold(1);
        push_px(7, 8, 9, 8, 1'b0);
        push_px(3, 3, 0, 1, 1'b1);

        set_threshold(30);
        queue_random_cells(40, 8);
        set_threshold($urandom_range(2000, 1));
        queue_random_cells(40, 8);

        set_idle(57, 10);
        set_threshold(0);
        queue_random_cells(40, 8);
        set_threshold(65535);
        queue_random_cells(40, 8);

        set_idle(0, 0);
        // One long cell of diagonal steps drives the busiest bin into saturation.
        set_threshold(200);
        queue_cell(130, GRAD_45);
        set_threshold($urandom_range(65535, 0));
        hold_gen <= hold_gen + 1;
        queue_random_cells(40, 3);
        set_threshold(1);
        queue_random_cells(40, 8);

        settle();
        $display("Run covered %0d pixel items in %0d cells, %0d bin results checked, %0s",
                 pixels_taken, cells_done, results_checked,
                 $sformatf("%0d saturating adds.", sat_adds));
        $display("Thresholds 0, 1, 30, 200, 65535 and random, %0s",
                 "with stalls on both sides and a long output hold.");
        if (errors == 0 && expected_bins.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tgch_pkg.sv
rtl/tgch_ram.sv
rtl/tgch_accum.sv
rtl/tgch_emit.sv
rtl/ternary_gradient_cell_histogram_core.sv
dv/tb_ternary_gradient_cell_histogram_core.sv
